// File: rtl/pcol_pkg.sv
// pcol_pkg: shared types and constants for particle_color_over_life
// no dependencies
package pcol_pkg;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned AgeW   = 24;
  localparam int unsigned PosW   = 16;
  localparam int unsigned TW     = 17;
  localparam int unsigned ColorW = 32;
  localparam int unsigned CountW = 4;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 4;
  localparam logic [TW-1:0] OneQ16 = 17'h10000;
  localparam logic [ColorW-1:0] WhiteWord = 32'hFFFF_FFFF;

  localparam logic [CmdW-1:0] CmdEval    = 2'd0;
  localparam logic [CmdW-1:0] CmdWrStop  = 2'd1;
  localparam logic [CmdW-1:0] CmdWrColor = 2'd2;

  localparam logic [ModeW-1:0] ModeGradient = 2'd0;
  localparam logic [ModeW-1:0] ModeDiscrete = 2'd1;

  localparam logic [CfgIdxW-1:0] RegColorMode  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegStopCount  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegColorCount = 2'd2;

  typedef enum logic [3:0] {
    StIdle,
    StDivAge,
    StSelect,
    StScanRd,
    StScanCmp,
    StDivFrac,
    StRdPair,
    StBlendLo,
    StBlendHi,
    StRdOne,
    StDone
  } pcol_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic div_start;  // start divider
    logic div_frac;   // 0: age/life, 1: segment fraction
    logic scan_first; // begin segment scan
    logic scan_next;  // advance scan index
    logic rd_pair;    // read seg i and i+1
    logic rd_one;     // read selected single entry
    logic blend_lo;   // capture low-side products
    logic blend_hi;   // capture high-side products and finish
    logic take_one;   // take single read as result
    logic set_white;
    logic set_invalid;
  } pcol_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_busy;
    logic is_eval;
    logic mode_grad;
    logic mode_disc;
    logic empty;
    logic clamp;      // result is a single entry without blending
    logic seg_hit;
    logic seg_zero;   // equal positions
    logic scan_end;
  } pcol_sts_t;

endpackage

// File: rtl/pcol_ram.sv
// pcol_ram: generic single-write RAM with registered read
// no dependencies
module pcol_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: rtl/pcol_div.sv
// pcol_div: restoring divider, one quotient bit per cycle
// computes floor((num << 16) / den) for num < den, 16-bit quotient
// depends on pcol_pkg
module pcol_div #(
  parameter int unsigned DenW = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DenW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [15:0]     quot_o
);
  import pcol_pkg::*;

  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [15:0]     quot_q, quot_d;
  logic [4:0]      cnt_q, cnt_d;
  logic [DenW:0]   shifted;
  logic            ge;

  assign shifted = {rem_q[DenW-1:0], 1'b0};
  assign ge      = shifted >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      rem_d  = {1'b0, num_i};
      quot_d = '0;
      cnt_d  = 5'd16;
    end else if (cnt_q != 5'd0) begin
      rem_d  = ge ? shifted - {1'b0, den_q} : shifted;
      quot_d = {quot_q[14:0], ge};
      cnt_d  = cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = start_i || (cnt_q != 5'd0);
  assign quot_o = quot_q;
endmodule

// File: rtl/pcol_ctrl.sv
// pcol_ctrl: sequencer for one item at a time
// depends on pcol_pkg
module pcol_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  pcol_pkg::pcol_sts_t   sts_i,
  output pcol_pkg::pcol_cmd_t   cmd_o
);
  import pcol_pkg::*;

  pcol_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        finish;

  // result register frees when taken, so the next item enters meanwhile
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:    if (in_valid_i && !(out_valid_q && out_stall_i)) state_d = StDivAge;
      StDivAge:  state_d = StSelect;
      StSelect: begin
        if (!sts_i.is_eval || !sts_i.mode_grad && !sts_i.mode_disc) state_d = StDone;
        else if (sts_i.div_busy) state_d = StSelect;
        else if (sts_i.empty) state_d = StDone;
        else if (sts_i.mode_disc || sts_i.clamp) state_d = StRdOne;
        else state_d = StScanRd;
      end
      StScanRd:  state_d = StScanCmp;
      StScanCmp: begin
        if (sts_i.seg_hit) state_d = sts_i.seg_zero ? StRdOne : StDivFrac;
        else if (sts_i.scan_end) state_d = StRdOne;
        else state_d = StScanRd;
      end
      StDivFrac: state_d = sts_i.div_busy ? StDivFrac : StRdPair;
      StRdPair:  state_d = StBlendLo;
      StBlendLo: state_d = StBlendHi;
      StBlendHi: state_d = StDone;
      StRdOne:   state_d = StDone;
      StDone:    state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    finish = 1'b0;
    case (state_q)
      StIdle: cmd_o.load = in_valid_i && !(out_valid_q && out_stall_i);
      StDivAge: cmd_o.div_start = 1'b1;
      StSelect: begin
        if (!sts_i.is_eval) cmd_o.set_invalid = 1'b1;
        else if (!sts_i.mode_grad && !sts_i.mode_disc) cmd_o.set_white = 1'b1;
        else if (!sts_i.div_busy) begin
          if (sts_i.empty) cmd_o.set_white = 1'b1;
          else if (sts_i.mode_disc || sts_i.clamp) cmd_o.rd_one = 1'b1;
          else cmd_o.scan_first = 1'b1;
        end
      end
      StScanCmp: begin
        if (sts_i.seg_hit && !sts_i.seg_zero) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_frac  = 1'b1;
        end else if (sts_i.seg_hit || sts_i.scan_end) begin
          cmd_o.rd_one = 1'b1;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      StRdPair:  cmd_o.rd_pair = 1'b1;
      StBlendLo: cmd_o.blend_lo = 1'b1;
      StBlendHi: cmd_o.blend_hi = 1'b1;
      StRdOne:   cmd_o.take_one = 1'b1;
      StDone:    finish = 1'b1;
      default:   ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (finish) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;
endmodule

// File: rtl/pcol_dpath.sv
// pcol_dpath: config registers, tables, divider and blend datapath
// depends on pcol_pkg, pcol_ram, pcol_div
module pcol_dpath #(
  parameter int unsigned MaxStops  = 8,
  parameter int unsigned MaxColors = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pcol_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pcol_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [pcol_pkg::CmdW-1:0]     command_i,
  input  logic                          active_i,
  input  logic [pcol_pkg::AgeW-1:0]     age_i,
  input  logic [pcol_pkg::AgeW-1:0]     lifetime_i,
  input  logic [2:0]                    entry_index_i,
  input  logic [pcol_pkg::PosW-1:0]     stop_position_i,
  input  logic [7:0]                    red_i,
  input  logic [7:0]                    green_i,
  input  logic [7:0]                    blue_i,
  input  logic [7:0]                    alpha_i,
  input  pcol_pkg::pcol_cmd_t           cmd_i,
  output pcol_pkg::pcol_sts_t           sts_o,
  output logic                          color_valid_o,
  output logic [7:0]                    color_red_o,
  output logic [7:0]                    color_green_o,
  output logic [7:0]                    color_blue_o,
  output logic [7:0]                    color_alpha_o
);
  import pcol_pkg::*;

  localparam int unsigned SAW = (MaxStops > 1) ? $clog2(MaxStops) : 1;
  localparam int unsigned CAW = (MaxColors > 1) ? $clog2(MaxColors) : 1;
  localparam int unsigned NW  = $clog2(MaxStops + 1);
  localparam int unsigned MW  = $clog2(MaxColors + 1);

  logic [ModeW-1:0]  mode_q;
  logic [CountW-1:0] nstop_q, ncol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      nstop_q <= '0;
      ncol_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegColorMode:  mode_q  <= cfg_data_i[ModeW-1:0];
        RegStopCount:  nstop_q <= cfg_data_i;
        RegColorCount: ncol_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // saturated counts
  logic [NW-1:0] n_eff;
  logic [MW-1:0] m_eff;
  assign n_eff = (32'(nstop_q) > MaxStops) ? NW'(MaxStops) : NW'(nstop_q);
  assign m_eff = (32'(ncol_q) > MaxColors) ? MW'(MaxColors) : MW'(ncol_q);

  // captured item
  logic             is_eval_q;
  logic [AgeW-1:0]  age_q, life_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      is_eval_q <= (command_i == CmdEval) && active_i;
      age_q     <= age_i;
      life_q    <= lifetime_i;
    end
  end

  // table writes happen at accept
  logic [ColorW-1:0] word;
  logic              wr_stop, wr_col;
  assign word    = {alpha_i, blue_i, green_i, red_i};
  assign wr_stop = cmd_i.load && (command_i == CmdWrStop) &&
                   (32'(entry_index_i) < MaxStops);
  assign wr_col  = cmd_i.load && (command_i == CmdWrColor) &&
                   (32'(entry_index_i) < MaxColors);

  // position table: flops, read at scan index and its neighbor
  logic [PosW-1:0] pos_q [MaxStops];
  always_ff @(posedge clk_i) begin
    if (wr_stop) pos_q[SAW'(entry_index_i)] <= stop_position_i;
  end

  // divider
  logic          div_busy;
  logic [15:0]   quot;
  logic [AgeW-1:0] div_num, div_den;
  logic [TW-1:0] t_q;
  logic          t_full_q;
  logic [SAW-1:0] seg_q;
  logic [PosW-1:0] lo_q, hi_q;

  assign div_num = cmd_i.div_frac ? AgeW'(t_q - TW'(lo_q)) : age_q;
  assign div_den = cmd_i.div_frac ? AgeW'(hi_q - lo_q) : life_q;

  pcol_div #(.DenW(AgeW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start && !cmd_i.div_frac) begin
      t_full_q <= (life_q == '0) || (age_q >= life_q);
    end
  end

  logic [TW-1:0] t;
  assign t = t_full_q ? OneQ16 : {1'b0, quot};

  // clamp test at select
  logic [PosW-1:0] p_first, p_last;
  assign p_first = pos_q[0];
  assign p_last  = pos_q[SAW'(n_eff - NW'(1))];

  // scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start && !cmd_i.div_frac) seg_q <= '0;
    if (cmd_i.scan_first) begin
      t_q   <= t;
      seg_q <= '0;
    end else if (cmd_i.scan_next) begin
      seg_q <= seg_q + SAW'(1);
    end
  end

  logic [SAW-1:0] seg_nx;
  assign seg_nx = seg_q + SAW'(1);
  always_ff @(posedge clk_i) begin
    lo_q <= pos_q[seg_q];
    hi_q <= pos_q[seg_nx];
  end

  logic seg_hit;
  assign seg_hit = (t_q >= TW'(lo_q)) && (t_q <= TW'(hi_q));

  // single read address
  logic [CAW-1:0]  disc_idx;
  logic [MW+TW-1:0] prod;
  assign prod = (MW+TW)'(t) * (MW+TW)'(m_eff);
  always_comb begin
    disc_idx = CAW'(prod[MW+TW-1:16]);
    if (32'(prod[MW+TW-1:16]) > 32'(m_eff) - 1) disc_idx = CAW'(m_eff - MW'(1));
  end

  // remembers that scanning began so a single read picks the segment
  logic state_in_scan_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_in_scan_q <= 1'b0;
    else if (cmd_i.scan_first) state_in_scan_q <= 1'b1;
    else if (cmd_i.load) state_in_scan_q <= 1'b0;
  end

  logic [SAW-1:0] one_addr_d, one_addr_q;
  logic           one_pal_q;
  always_comb begin
    if (mode_q == ModeDiscrete) one_addr_d = '0;
    else if (state_in_scan_q && seg_hit) one_addr_d = seg_q;
    else if (state_in_scan_q) one_addr_d = '0;
    else if (t <= TW'(p_first)) one_addr_d = '0;
    else one_addr_d = SAW'(n_eff - NW'(1));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_one) begin
      one_pal_q  <= (mode_q == ModeDiscrete);
      one_addr_q <= one_addr_d;
    end
  end

  logic [CAW-1:0] pal_addr_q, pal_raddr;
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_one) pal_addr_q <= disc_idx;
  end
  // the single read is issued in the same cycle the address is chosen
  assign pal_raddr = cmd_i.rd_one ? disc_idx : pal_addr_q;

  // color memories: stop colors read at seg then seg+1 in turn
  logic [SAW-1:0]    sc_raddr;
  logic [ColorW-1:0] sc_rdata, pal_rdata;
  assign sc_raddr = cmd_i.rd_one   ? one_addr_d :
                    cmd_i.blend_lo ? seg_nx :
                    (cmd_i.rd_pair ? seg_q : one_addr_q);

  pcol_ram #(.Width(ColorW), .Depth(MaxStops)) u_stop_ram (
    .clk_i   (clk_i),
    .we_i    (wr_stop),
    .waddr_i (SAW'(entry_index_i)),
    .wdata_i (word),
    .raddr_i (sc_raddr),
    .rdata_o (sc_rdata)
  );

  pcol_ram #(.Width(ColorW), .Depth(MaxColors)) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (wr_col),
    .waddr_i (CAW'(entry_index_i)),
    .wdata_i (word),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rdata)
  );

  // blend: per channel an 8x17 multiply, then an 8x16 multiply, in two steps
  logic [15:0]  f_q;
  logic [16:0]  wlo;
  logic [24:0]  acc_q [4];
  logic [ColorW-1:0] res_q;
  logic              res_v_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_pair) f_q <= quot;
  end
  assign wlo = OneQ16 - {1'b0, f_q};

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      if (cmd_i.blend_lo) acc_q[k] <= 25'(sc_rdata[8*k +: 8]) * 25'(wlo);
    end
  end

  logic [24:0] sum [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum[k] = acc_q[k] + 25'(sc_rdata[8*k +: 8]) * 25'(f_q) + 25'd32768;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_invalid) begin
      res_q   <= '0;
      res_v_q <= 1'b0;
    end else if (cmd_i.set_white) begin
      res_q   <= WhiteWord;
      res_v_q <= 1'b1;
    end else if (cmd_i.take_one) begin
      res_q   <= one_pal_q ? pal_rdata : sc_rdata;
      res_v_q <= 1'b1;
    end else if (cmd_i.blend_hi) begin
      for (int k = 0; k < 4; k++) res_q[8*k +: 8] <= sum[k][23:16];
      res_v_q <= 1'b1;
    end
  end

  assign sts_o.div_busy  = div_busy;
  assign sts_o.is_eval   = is_eval_q;
  assign sts_o.mode_grad = (mode_q == ModeGradient);
  assign sts_o.mode_disc = (mode_q == ModeDiscrete);
  assign sts_o.empty     = (mode_q == ModeDiscrete) ? (m_eff == '0) : (n_eff == '0);
  assign sts_o.clamp     = (t <= TW'(p_first)) || (t >= TW'(p_last));
  assign sts_o.seg_hit   = seg_hit;
  assign sts_o.seg_zero  = (hi_q == lo_q);
  assign sts_o.scan_end  = (32'(seg_q) + 2 >= 32'(n_eff));

  assign color_valid_o = res_v_q;
  assign color_red_o   = res_q[7:0];
  assign color_green_o = res_q[15:8];
  assign color_blue_o  = res_q[23:16];
  assign color_alpha_o = res_q[31:24];
endmodule

// File: rtl/particle_color_over_life.sv
// particle_color_over_life: top level, controller plus datapath
// depends on pcol_pkg, pcol_ctrl, pcol_dpath
//
//   channel | handshake             | payload
//   in      | in_valid_i/in_stall_o | command_i .. alpha_i
//   out     | out_valid_o/out_stall_i | color_valid_o .. color_alpha_o
//   cfg     | cfg_we_i              | cfg_index_i, cfg_data_i
//
// loads, inactive items and white mode go from select straight to done; empty
// tables and clamped or discrete evaluations wait for the age/life division;
// tied stops or an unmatched scan add a read and compare per segment scanned;
// interpolation reruns the shared divider for the fraction. one item in flight; a
// waiting result stalls the input until it is taken. no clearing pass after reset.
module particle_color_over_life #(
  parameter int unsigned MAX_GRADIENT_STOPS = 8,
  parameter int unsigned MAX_PALETTE_COLORS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pcol_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pcol_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pcol_pkg::CmdW-1:0]     command_i,
  input  logic                          active_i,
  input  logic [pcol_pkg::AgeW-1:0]     age_i,
  input  logic [pcol_pkg::AgeW-1:0]     lifetime_i,
  input  logic [2:0]                    entry_index_i,
  input  logic [pcol_pkg::PosW-1:0]     stop_position_i,
  input  logic [7:0]                    red_i,
  input  logic [7:0]                    green_i,
  input  logic [7:0]                    blue_i,
  input  logic [7:0]                    alpha_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          color_valid_o,
  output logic [7:0]                    color_red_o,
  output logic [7:0]                    color_green_o,
  output logic [7:0]                    color_blue_o,
  output logic [7:0]                    color_alpha_o
);
  import pcol_pkg::*;

  pcol_cmd_t cmd;
  pcol_sts_t sts;

  pcol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pcol_dpath #(
    .MaxStops  (MAX_GRADIENT_STOPS),
    .MaxColors (MAX_PALETTE_COLORS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .command_i       (command_i),
    .active_i        (active_i),
    .age_i           (age_i),
    .lifetime_i      (lifetime_i),
    .entry_index_i   (entry_index_i),
    .stop_position_i (stop_position_i),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .alpha_i         (alpha_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .color_valid_o   (color_valid_o),
    .color_red_o     (color_red_o),
    .color_green_o   (color_green_o),
    .color_blue_o    (color_blue_o),
    .color_alpha_o   (color_alpha_o)
  );

  // an accepted item means the block was free of other work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("accept did not start work");

  // no two datapath actions at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.div_start, cmd.rd_pair, cmd.blend_lo, cmd.blend_hi,
              cmd.take_one, cmd.set_white, cmd.set_invalid}))
    else $error("conflicting datapath commands");

  // a waiting result is not replaced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(color_red_o))
    else $error("result lost under stall");
endmodule
